// ----- src/lfh_pkg.sv -----
// ----------------------------------------------------------------------------
// lfh_pkg
// Shared types, constants and letter mapping functions for the letter
// frequency histogram core.
// ----------------------------------------------------------------------------
package lfh_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int NUM_LETTERS     = 52;
    localparam int ALPHA_SIZE      = 26;
    localparam int IDX_W           = $clog2(NUM_LETTERS);
    localparam int OUT_COUNT_W     = 16;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic hit;
        idx_t slot;
    } slot_t;

    // Controller commands toward the datapath
    typedef struct packed {
        logic in_ready;
        logic scan_rd;
        logic load_letter;
        logic load_empty;
        logic idx_inc;
        logic clear_all;
    } lfh_cmd_t;

    // Datapath status toward the controller
    typedef struct packed {
        logic end_fire;
        logic any_valid;
        logic cur_valid;
        logic tail_empty;
        logic out_free;
    } lfh_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD
    } state_t;

    // Byte to counter slot: uppercase first, then lowercase
    function automatic slot_t slot_of(input logic [7:0] c);
        slot_t r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            d     = c - CHAR_UPPER_A;
            r.hit = 1'b1;
            r.slot = d[IDX_W-1:0];
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            d     = c - CHAR_LOWER_A + 8'(ALPHA_SIZE);
            r.hit = 1'b1;
            r.slot = d[IDX_W-1:0];
        end
        return r;
    endfunction

    // Counter slot back to ASCII code
    function automatic logic [7:0] code_of(input idx_t s);
        logic [7:0] r;
        if (s < IDX_W'(ALPHA_SIZE)) begin
            r = CHAR_UPPER_A + 8'(s);
        end else begin
            r = CHAR_LOWER_A + 8'(s) - 8'(ALPHA_SIZE);
        end
        return r;
    endfunction

endpackage

// ----- src/lfh_datapath.sv -----
// ----------------------------------------------------------------------------
// lfh_datapath
// Counter memory with per-entry valid bits, read-modify-write increment
// pipeline with write bypass, scan index and result output register.
// ----------------------------------------------------------------------------
module lfh_datapath
    import lfh_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lfh_cmd_t               cmd,
    output lfh_status_t            status,
    input  logic                   s_valid,
    input  logic [7:0]             s_symbol,
    input  logic                   s_end_marker,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_letter,
    output logic [OUT_COUNT_W-1:0] m_count,
    output logic                   m_no_letters,
    output logic                   m_last
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] mem [0:NUM_LETTERS-1];

    logic [NUM_LETTERS-1:0] valid_reg, valid_next;
    idx_t                   idx_reg, idx_next;

    logic                   s1_vld_reg;
    idx_t                   s1_slot_reg;
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic                   rd_valid_reg;

    logic                   wr_vld_reg;
    idx_t                   wr_slot_reg;
    logic [COUNT_WIDTH-1:0] wr_data_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_letter_reg;
    logic [OUT_COUNT_W-1:0] m_count_reg;
    logic                   m_no_letters_reg;
    logic                   m_last_reg;

    logic                   in_fire;
    logic                   byte_fire;
    slot_t                  in_slot;
    logic                   rd_en;
    idx_t                   rd_addr;
    logic [COUNT_WIDTH-1:0] base;
    logic [COUNT_WIDTH-1:0] incr;
    logic [NUM_LETTERS-1:0] above_mask;
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] cnt_ext;
    logic [OUT_COUNT_W-1:0] cnt_clip;

    // Input handshake and letter decode
    assign in_fire   = s_valid && cmd.in_ready;
    assign byte_fire = in_fire && !s_end_marker;
    assign in_slot   = slot_of(s_symbol);

    assign rd_en   = cmd.scan_rd || (byte_fire && in_slot.hit);
    assign rd_addr = cmd.scan_rd ? idx_reg : in_slot.slot;

    // Increment stage: bypass the write of the previous beat
    always_comb begin
        if (wr_vld_reg && wr_slot_reg == s1_slot_reg) begin
            base = wr_data_reg;
        end else if (rd_valid_reg) begin
            base = rd_data_reg;
        end else begin
            base = '0;
        end
        incr = (base == COUNT_MAX) ? base : base + COUNT_WIDTH'(1);
    end

    // Memory read and write ports
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (s1_vld_reg) begin
            mem[s1_slot_reg] <= incr;
        end
    end

    // Payload of the write bypass
    always_ff @(posedge aclk) begin
        s1_slot_reg <= in_slot.slot;
        wr_slot_reg <= s1_slot_reg;
        wr_data_reg <= incr;
    end

    // Valid bits: set on write, all cleared at report end
    always_comb begin
        valid_next = valid_reg;
        if (cmd.clear_all) begin
            valid_next = '0;
        end
        if (s1_vld_reg) begin
            valid_next[s1_slot_reg] = 1'b1;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.clear_all) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            idx_reg    <= '0;
            s1_vld_reg <= 1'b0;
            wr_vld_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            idx_reg    <= idx_next;
            s1_vld_reg <= byte_fire && in_slot.hit;
            wr_vld_reg <= s1_vld_reg;
        end
    end

    // Slots beyond the scan index
    always_comb begin
        for (int i = 0; i < NUM_LETTERS; i++) begin
            above_mask[i] = (IDX_W'(i) > idx_reg);
        end
    end

    // Clip wide counts to the output field
    assign cnt_ext  = {{OUT_COUNT_W{1'b0}}, rd_data_reg};
    assign cnt_clip = (cnt_ext[COUNT_WIDTH+OUT_COUNT_W-1:OUT_COUNT_W] != '0) ?
                      {OUT_COUNT_W{1'b1}} : cnt_ext[OUT_COUNT_W-1:0];

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_letter || cmd.load_empty) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_empty) begin
            m_letter_reg     <= '0;
            m_count_reg      <= '0;
            m_no_letters_reg <= 1'b1;
            m_last_reg       <= 1'b1;
        end else if (cmd.load_letter) begin
            m_letter_reg     <= code_of(idx_reg);
            m_count_reg      <= cnt_clip;
            m_no_letters_reg <= 1'b0;
            m_last_reg       <= ((valid_reg & above_mask) == '0);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_letter     = m_letter_reg;
    assign m_count      = m_count_reg;
    assign m_no_letters = m_no_letters_reg;
    assign m_last       = m_last_reg;

    // Status toward the controller
    assign status.end_fire   = in_fire && s_end_marker;
    assign status.any_valid  = (valid_reg != '0);
    assign status.cur_valid  = valid_reg[idx_reg];
    assign status.tail_empty = ((valid_reg & above_mask) == '0);
    assign status.out_free   = !m_valid_reg || m_ready;

endmodule

// ----- src/lfh_ctrl.sv -----
// ----------------------------------------------------------------------------
// lfh_ctrl
// Sequencer: accepts bytes in idle, walks the counter slots on an end marker
// and issues reads and result loads, then clears the histogram.
// ----------------------------------------------------------------------------
module lfh_ctrl
    import lfh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  lfh_status_t status,
    output lfh_cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (status.end_fire) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!status.any_valid) begin
                    // empty string: single flagged result
                    if (status.out_free) begin
                        cmd.load_empty = 1'b1;
                        cmd.clear_all  = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (status.cur_valid) begin
                    if (status.out_free) begin
                        cmd.scan_rd = 1'b1;
                        state_next  = ST_LOAD;
                    end
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_LOAD: begin
                cmd.load_letter = 1'b1;
                if (status.tail_empty) begin
                    cmd.clear_all = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/letter_frequency_histogram_core.sv -----
// ----------------------------------------------------------------------------
// letter_frequency_histogram_core
// Counts the 52 ASCII letters of a byte stream and reports the non-zero
// counts, uppercase then lowercase, when an end marker arrives.
//
//   channel   ports                                       role
//   s_        s_valid s_ready s_symbol s_end_marker         byte in / end
//   m_        m_valid m_ready m_letter m_count              result out
//             m_no_letters m_last
//
// Bytes are taken one per cycle while idle; the counter memory
// read-modify-write is pipelined through a read register and an
// increment stage with a bypass for repeated letters. On an end marker
// the scan walks the slots up to the last non-zero one, skipping empty
// slots and waiting on m_ready for each letter. s_ready is low during the scan.
// No clearing pass: per-slot valid bits are reset at once.
// ----------------------------------------------------------------------------
module letter_frequency_histogram_core
    import lfh_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_symbol,
    input  logic                   s_end_marker,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_letter,
    output logic [OUT_COUNT_W-1:0] m_count,
    output logic                   m_no_letters,
    output logic                   m_last
);

    lfh_cmd_t    cmd;
    lfh_status_t status;

    assign s_ready = cmd.in_ready;

    lfh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    lfh_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_valid      (s_valid),
        .s_symbol     (s_symbol),
        .s_end_marker (s_end_marker),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_letter     (m_letter),
        .m_count      (m_count),
        .m_no_letters (m_no_letters),
        .m_last       (m_last)
    );

endmodule

// ----- src/lfh_checker.sv -----
// ----------------------------------------------------------------------------
// lfh_checker
// Port-level checks on the result channel of the histogram core.
// ----------------------------------------------------------------------------
module lfh_checker
    import lfh_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [7:0]             m_letter,
    input logic [OUT_COUNT_W-1:0] m_count,
    input logic                   m_no_letters,
    input logic                   m_last
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // empty report is a single zero beat closing the report
    a_empty_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_no_letters) |-> (m_last && m_letter == '0 && m_count == '0))
        else $error("malformed no_letters beat");

    // reported letter is a letter with a non-zero count
    a_letter_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_no_letters) |->
            (m_count != '0 &&
             ((m_letter >= CHAR_UPPER_A && m_letter <= CHAR_UPPER_Z) ||
              (m_letter >= CHAR_LOWER_A && m_letter <= CHAR_LOWER_Z))))
        else $error("bad letter beat");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_letter) && $stable(m_count)))
        else $error("result changed while stalled");

endmodule

bind letter_frequency_histogram_core lfh_checker u_lfh_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_letter     (m_letter),
    .m_count      (m_count),
    .m_no_letters (m_no_letters),
    .m_last       (m_last)
);

// ----- verif/tb_letter_frequency_histogram_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_letter_frequency_histogram_core
// Self-checking bench for the letter histogram core. A directed table covers
// empty strings, the letter range edges and non-letter bytes. Random strings
// follow, with random gaps and stalls on both channels. Every reported beat
// is checked against a table entry or a behavioral histogram.
// ----------------------------------------------------------------------------
module tb_letter_frequency_histogram_core;
    import lfh_pkg::*;

    localparam int unsigned TALLY_MAX = (COUNT_WIDTH_DEF >= 32) ? 32'hFFFF_FFFF
                                      : ((32'd1 << COUNT_WIDTH_DEF) - 32'd1);
    localparam int RANDOM_ITEMS = 190;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [7:0]             letter;
        logic [OUT_COUNT_W-1:0] count;
        logic                   none;
        logic                   last;
    } report_t;

    typedef struct {
        logic [7:0] sym;
        logic       endm;
        int         reps;
        bit         typed;
        report_t    want;
    } plan_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_symbol = 8'h00;
    logic                   s_end_marker = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [7:0]             m_letter;
    logic [OUT_COUNT_W-1:0] m_count;
    logic                   m_no_letters;
    logic                   m_last;

    int unsigned tally [NUM_LETTERS];
    report_t     report_q [$];
    plan_row_t   plan [$];
    int          mismatches = 0;
    int          items_sent = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;

    letter_frequency_histogram_core u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_symbol     (s_symbol),
        .s_end_marker (s_end_marker),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_letter     (m_letter),
        .m_count      (m_count),
        .m_no_letters (m_no_letters),
        .m_last       (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Histogram slot of a byte, -1 for anything that is not a letter
    function automatic int letter_slot(input logic [7:0] b);
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return int'(b - CHAR_UPPER_A);
        if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) return ALPHA_SIZE + int'(b - CHAR_LOWER_A);
        return -1;
    endfunction

    function automatic logic [7:0] slot_code(input int s);
        if (s < ALPHA_SIZE) return CHAR_UPPER_A + 8'(s);
        return CHAR_LOWER_A + 8'(s - ALPHA_SIZE);
    endfunction

    // Single-beat report with last set, for rows whose outcome is obvious
    function automatic report_t final_report(input logic [7:0] letter, input int unsigned cnt,
                                             input logic none);
        report_t r;
        r.letter = letter;
        r.count  = OUT_COUNT_W'(cnt);
        r.none   = none;
        r.last   = 1'b1;
        return r;
    endfunction

    task automatic add_row(input logic [7:0] sym, input logic endm, input int reps,
                           input bit typed, input report_t want);
        plan_row_t row;
        row.sym   = sym;
        row.endm  = endm;
        row.reps  = reps;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endtask

    // Update the histogram for one byte; on an end marker queue the report
    task automatic histogram_step(input logic [7:0] sym, input logic endm,
                                  input bit typed, input report_t want);
        int      s;
        int      i;
        bit      have_held;
        report_t held;
        report_t r;
        if (!endm) begin
            s = letter_slot(sym);
            if (s >= 0 && tally[s] != TALLY_MAX) tally[s]++;
        end else begin
            if (typed) begin
                report_q.push_back(want);
            end else begin
                have_held = 1'b0;
                held = '0;
                for (i = 0; i < NUM_LETTERS; i++) begin
                    if (tally[i] != 0) begin
                        if (have_held) report_q.push_back(held);
                        r.letter = slot_code(i);
                        r.count  = (tally[i] > 32'hFFFF) ? 16'hFFFF : tally[i][15:0];
                        r.none   = 1'b0;
                        r.last   = 1'b0;
                        held = r;
                        have_held = 1'b1;
                    end
                end
                if (!have_held) begin
                    held = '0;
                    held.none = 1'b1;
                end
                held.last = 1'b1;
                report_q.push_back(held);
            end
            for (i = 0; i < NUM_LETTERS; i++) tally[i] = 0;
        end
    endtask

    // Offer one beat and wait until it is taken
    task automatic send_beat(input logic [7:0] sym, input logic endm, input bit may_idle,
                             input bit typed, input report_t want);
        int gap;
        gap = (may_idle && !calm) ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_symbol     <= sym;
        s_end_marker <= endm;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        histogram_step(sym, endm, typed, want);
        items_sent++;
    endtask

    // Hold the input side quiet until every queued result has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (report_q.size() != 0) @(posedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : drive_ready
        int stall;
        int held;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge aclk);
                    held++;
                end
                hold_req = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid && !hold_req) @(posedge aclk);
        end
    end

    // Compare each result beat with the oldest expected report entry
    always @(posedge aclk) begin : check_results
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (report_q.size() == 0) begin
                $display("%0t ns: unexpected result beat letter=%h count=%0d none=%b last=%b",
                         $time, m_letter, m_count, m_no_letters, m_last);
                mismatches++;
            end else begin
                want = report_q.pop_front();
                if (m_letter !== want.letter || m_count !== want.count ||
                    m_no_letters !== want.none || m_last !== want.last) begin
                    $display("%0t ns: expected letter=%h count=%0d none=%b last=%b",
                             $time, want.letter, want.count, want.none, want.last);
                    $display("%0t ns: actual   letter=%h count=%0d none=%b last=%b",
                             $time, m_letter, m_count, m_no_letters, m_last);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus: directed table, then random strings
    initial begin : stimulus
        int      k;
        int      j;
        int      len;
        int      kind;
        int      off;
        int      str_idx;
        report_t nil;
        logic [7:0] b;

        nil = '0;
        for (k = 0; k < NUM_LETTERS; k++) tally[k] = 0;

        // Empty string right after reset
        add_row(8'hFF, 1'b1, 1, 1'b1, final_report(8'h00, 0, 1'b1));
        // Single letter
        add_row(CHAR_UPPER_A, 1'b0, 1, 1'b0, nil);
        add_row(CHAR_UPPER_A, 1'b1, 1, 1'b1, final_report(CHAR_UPPER_A, 1, 1'b0));
        // Range edges and the bytes just outside them
        add_row(CHAR_UPPER_Z, 1'b0, 1, 1'b0, nil);
        add_row(CHAR_LOWER_A, 1'b0, 1, 1'b0, nil);
        add_row(CHAR_LOWER_Z, 1'b0, 1, 1'b0, nil);
        add_row(8'h40, 1'b0, 1, 1'b0, nil);
        add_row(8'h5B, 1'b0, 1, 1'b0, nil);
        add_row(8'h60, 1'b0, 1, 1'b0, nil);
        add_row(8'h7B, 1'b0, 1, 1'b0, nil);
        add_row(8'h00, 1'b0, 1, 1'b0, nil);
        add_row(8'h80, 1'b0, 1, 1'b0, nil);
        add_row(8'hFF, 1'b0, 1, 1'b0, nil);
        add_row(CHAR_LOWER_A, 1'b0, 3, 1'b0, nil);
        // Letter on the end marker beat must not count
        add_row(CHAR_UPPER_A, 1'b1, 1, 1'b0, nil);
        // Only non-letters
        add_row(8'h7F, 1'b0, 1, 1'b0, nil);
        add_row(8'h20, 1'b0, 2, 1'b0, nil);
        add_row(8'h00, 1'b1, 1, 1'b1, final_report(8'h00, 0, 1'b1));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (k = 0; k < plan.size(); k++) begin
            for (j = 0; j < plan[k].reps; j++) begin
                send_beat(plan[k].sym, plan[k].endm, j == 0, plan[k].typed, plan[k].want);
            end
        end
        wait_drained();

        // Random strings; the first one runs into a long result hold-off
        items_sent = 0;
        str_idx = 0;
        hold_req = 1'b1;
        while (items_sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 4) == 0);
            if (str_idx == 12) wait_drained();
            kind = $urandom_range(0, 9);
            case (kind)
                0: begin
                    // every letter, permuted
                    off = $urandom_range(0, NUM_LETTERS - 1);
                    for (j = 0; j < NUM_LETTERS; j++) begin
                        send_beat(slot_code((off + j * 7) % NUM_LETTERS), 1'b0, 1'b1,
                                  1'b0, nil);
                    end
                end
                1: begin
                    // raw noise bytes
                    len = $urandom_range(0, 6);
                    for (j = 0; j < len; j++) begin
                        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, nil);
                    end
                end
                2: begin
                    // bare end marker
                end
                default: begin
                    // mostly letters with some other bytes mixed in
                    len = $urandom_range(1, 12);
                    for (j = 0; j < len; j++) begin
                        if ($urandom_range(0, 4) != 0) begin
                            b = slot_code($urandom_range(0, NUM_LETTERS - 1));
                        end else begin
                            b = 8'($urandom_range(0, 255));
                        end
                        send_beat(b, 1'b0, 1'b1, 1'b0, nil);
                    end
                end
            endcase
            send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1, 1'b0, nil);
            str_idx++;
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        // Drain and settle
        @(posedge aclk);
        while (report_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (report_q.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived", $time, report_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
src/lfh_pkg.sv
src/lfh_datapath.sv
src/lfh_ctrl.sv
src/letter_frequency_histogram_core.sv
src/lfh_checker.sv
verif/tb_letter_frequency_histogram_core.sv
